/* sv/cpp_pkg.sv */
// types and constants shared by the contiguous partition placer
// request and result payloads, configuration indexes, shared unit codes
// no dependencies
package cpp_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic CFG_REGION_BASE   = 1'b0;
    localparam logic CFG_REGION_LENGTH = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [1:0]  slot_index;
        logic [31:0] slot_begin;
        logic [31:0] slot_length;
        logic        slot_in_use;
        logic [31:0] request_length;
        logic [1:0]  fit_policy;
    } t_in;

    typedef struct packed {
        logic        success;
        logic [31:0] placed_begin;
        logic [1:0]  placed_slot;
    } t_out;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic        lt;
        logic        zero;
        logic [32:0] value;
    } t_alu_res;

endpackage

/* sv/contiguous_partition_placer.sv */
// top level of the contiguous partition placer: slot table, sorter and gap scan
// sequencer driving one shared add/subtract unit
// depends on cpp_pkg and cpp_alu
//
// A load request writes one table slot; its result passes through the done state
// into the output register. An allocate request is worked through one add or
// compare per cycle on the shared unit: the used slots are sorted by repeated
// selection passes (one per used slot plus a final pass, which a full table skips,
// failing the allocate), then the gaps are scanned in address order through the
// minimum, subtract, fit, policy, extent add and extent compare steps as needed,
// then, if a gap fits, the table is rewritten in the write state. The request side
// is not ready while a request is being worked on; a finished result sits in an
// output register, so the next request is taken while that result waits.
module contiguous_partition_placer import cpp_pkg::*; #(
    parameter int SLOT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam int XW = (NW > 2) ? NW : 2;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_SORT_CMP = 12'b0000_0000_0010,
        ST_SORT_PUT = 12'b0000_0000_0100,
        ST_END_ADD  = 12'b0000_0000_1000,
        ST_GAP_MIN  = 12'b0000_0001_0000,
        ST_GAP_SUB  = 12'b0000_0010_0000,
        ST_FIT_CMP  = 12'b0000_0100_0000,
        ST_POL_CMP  = 12'b0000_1000_0000,
        ST_EXT_ADD  = 12'b0001_0000_0000,
        ST_EXT_CMP  = 12'b0010_0000_0000,
        ST_WRITE    = 12'b0100_0000_0000,
        ST_DONE     = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_out   r_out, n_out;
    t_out   r_res, n_res;

    logic [31:0] r_base, r_len;

    logic [31:0] r_eb [SLOT_COUNT];
    logic [31:0] r_el [SLOT_COUNT];
    logic        r_eu [SLOT_COUNT];
    logic [31:0] n_eb [SLOT_COUNT];
    logic [31:0] n_el [SLOT_COUNT];
    logic        n_eu [SLOT_COUNT];

    logic [31:0] r_sb [SLOT_COUNT];
    logic [31:0] r_sl [SLOT_COUNT];
    logic [31:0] n_sb [SLOT_COUNT];
    logic [31:0] n_sl [SLOT_COUNT];

    logic [SLOT_COUNT-1:0] r_taken, n_taken;
    logic [IW-1:0]         r_j, n_j;
    logic [IW-1:0]         r_best_idx, n_best_idx;
    logic                  r_have, n_have;
    logic [31:0]           r_best_begin, n_best_begin;
    logic [31:0]           r_best_len, n_best_len;
    logic [NW-1:0]         r_n, n_n;
    logic [NW-1:0]         r_k, n_k;
    logic [NW-1:0]         r_bpos, n_bpos;
    logic [32:0]           r_end, n_end;
    logic [32:0]           r_cursor, n_cursor;
    logic [32:0]           r_gap_end, n_gap_end;
    logic [32:0]           r_size, n_size;
    logic [32:0]           r_bsize, n_bsize;
    logic [32:0]           r_ext, n_ext;
    logic [31:0]           r_bstart, n_bstart;
    logic [31:0]           r_req, n_req;
    logic [1:0]            r_policy, n_policy;
    logic                  r_found, n_found;

    t_alu_op     w_alu_op;
    logic [32:0] w_alu_a, w_alu_b;
    t_alu_res    w_alu;
    logic        w_take;
    logic        w_found_now;
    logic [IW-1:0] w_kidx;
    logic [XW-1:0] w_load_idx;
    logic [XW-1:0] w_bpos_ext;
    t_state        w_scan_next;

    assign w_kidx     = r_k[IW-1:0];
    assign w_load_idx = XW'(i_in_data.slot_index);
    assign w_bpos_ext = XW'(r_bpos);

    cpp_alu u_alu (
        .i_op  (w_alu_op),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu)
    );

    // operand selection for the shared unit
    always_comb begin
        w_alu_op = ALU_SUB;
        w_alu_a  = '0;
        w_alu_b  = '0;
        unique case (r_state)
            ST_SORT_CMP: begin
                w_alu_a = {1'b0, r_eb[r_j]};
                w_alu_b = {1'b0, r_best_begin};
            end
            ST_END_ADD: begin
                w_alu_op = ALU_ADD;
                w_alu_a  = {1'b0, r_base};
                w_alu_b  = {1'b0, r_len};
            end
            ST_GAP_MIN: begin
                w_alu_a = {1'b0, r_sb[w_kidx]};
                w_alu_b = r_end;
            end
            ST_GAP_SUB: begin
                w_alu_a = r_gap_end;
                w_alu_b = r_cursor;
            end
            ST_FIT_CMP: begin
                w_alu_a = r_size;
                w_alu_b = {1'b0, r_req};
            end
            ST_POL_CMP: begin
                w_alu_a = r_size;
                w_alu_b = r_bsize;
            end
            ST_EXT_ADD: begin
                w_alu_op = ALU_ADD;
                w_alu_a  = {1'b0, r_sb[w_kidx]};
                w_alu_b  = {1'b0, r_sl[w_kidx]};
            end
            ST_EXT_CMP: begin
                w_alu_a = r_ext;
                w_alu_b = r_cursor;
            end
            default: begin
                w_alu_op = ALU_SUB;
            end
        endcase
    end

    // gap selection
    always_comb begin
        w_take = 1'b0;
        if (r_state == ST_FIT_CMP) begin
            w_take = !w_alu.lt && !r_found;
        end else if (r_state == ST_POL_CMP) begin
            w_take = ((r_policy == POL_BEST) && w_alu.lt) ||
                     ((r_policy == POL_WORST) && !w_alu.lt && !w_alu.zero);
        end
    end

    assign w_found_now = r_found | w_take;

    always_comb begin
        if (r_k < r_n) begin
            w_scan_next = ST_EXT_ADD;
        end else if (w_found_now) begin
            w_scan_next = ST_WRITE;
        end else begin
            w_scan_next = ST_DONE;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_eb         = r_eb;
        n_el         = r_el;
        n_eu         = r_eu;
        n_sb         = r_sb;
        n_sl         = r_sl;
        n_taken      = r_taken;
        n_j          = r_j;
        n_best_idx   = r_best_idx;
        n_have       = r_have;
        n_best_begin = r_best_begin;
        n_best_len   = r_best_len;
        n_n          = r_n;
        n_k          = r_k;
        n_bpos       = r_bpos;
        n_end        = r_end;
        n_cursor     = r_cursor;
        n_gap_end    = r_gap_end;
        n_size       = r_size;
        n_bsize      = r_bsize;
        n_ext        = r_ext;
        n_bstart     = r_bstart;
        n_req        = r_req;
        n_policy     = r_policy;
        n_found      = r_found;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.cmd == CMD_LOAD) begin
                        for (int w = 0; w < SLOT_COUNT; w++) begin
                            if (w_load_idx == XW'(w)) begin
                                n_eb[w] = i_in_data.slot_begin;
                                n_el[w] = i_in_data.slot_length;
                                n_eu[w] = i_in_data.slot_in_use;
                            end
                        end
                        n_res.success      = (w_load_idx < XW'(SLOT_COUNT));
                        n_res.placed_begin = '0;
                        n_res.placed_slot  = i_in_data.slot_index;
                        n_state            = ST_DONE;
                    end else begin
                        n_req    = i_in_data.request_length;
                        n_policy = i_in_data.fit_policy;
                        n_n      = '0;
                        n_taken  = '0;
                        n_j      = '0;
                        n_have   = 1'b0;
                        n_res    = '0;
                        n_state  = ST_SORT_CMP;
                    end
                end
            end
            ST_SORT_CMP: begin
                if (r_eu[r_j] && !r_taken[r_j] && (!r_have || w_alu.lt)) begin
                    n_have       = 1'b1;
                    n_best_idx   = r_j;
                    n_best_begin = r_eb[r_j];
                    n_best_len   = r_el[r_j];
                end
                if (r_j == IW'(SLOT_COUNT - 1)) begin
                    n_state = ST_SORT_PUT;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_SORT_PUT: begin
                if (r_have) begin
                    n_sb[r_n[IW-1:0]]    = r_best_begin;
                    n_sl[r_n[IW-1:0]]    = r_best_len;
                    n_taken[r_best_idx] = 1'b1;
                    n_n                 = r_n + 1'b1;
                    n_j                 = '0;
                    n_have              = 1'b0;
                    if (r_n == NW'(SLOT_COUNT - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SORT_CMP;
                    end
                end else begin
                    n_state = ST_END_ADD;
                end
            end
            ST_END_ADD: begin
                n_end    = w_alu.value[32] ? {1'b1, 32'd0} : w_alu.value;
                n_cursor = {1'b0, r_base};
                n_k      = '0;
                n_found  = 1'b0;
                n_state  = ST_GAP_MIN;
            end
            ST_GAP_MIN: begin
                if ((r_k < r_n) && w_alu.lt) begin
                    n_gap_end = {1'b0, r_sb[w_kidx]};
                end else begin
                    n_gap_end = r_end;
                end
                n_state = ST_GAP_SUB;
            end
            ST_GAP_SUB: begin
                if (!w_alu.lt && !w_alu.zero) begin
                    n_size  = w_alu.value;
                    n_state = ST_FIT_CMP;
                end else begin
                    n_state = w_scan_next;
                end
            end
            ST_FIT_CMP: begin
                if (!w_alu.lt && r_found &&
                    ((r_policy == POL_BEST) || (r_policy == POL_WORST))) begin
                    n_state = ST_POL_CMP;
                end else begin
                    n_state = w_scan_next;
                end
            end
            ST_POL_CMP: begin
                n_state = w_scan_next;
            end
            ST_EXT_ADD: begin
                n_ext   = w_alu.value;
                n_state = ST_EXT_CMP;
            end
            ST_EXT_CMP: begin
                if (!w_alu.lt && !w_alu.zero) begin
                    n_cursor = r_ext;
                end
                n_k     = r_k + 1'b1;
                n_state = ST_GAP_MIN;
            end
            ST_WRITE: begin
                for (int w = 0; w < SLOT_COUNT; w++) begin
                    if (NW'(w) < r_bpos) begin
                        n_eb[w] = r_sb[w];
                        n_el[w] = r_sl[w];
                        n_eu[w] = 1'b1;
                    end else if (NW'(w) == r_bpos) begin
                        n_eb[w] = r_bstart;
                        n_el[w] = r_req;
                        n_eu[w] = 1'b1;
                    end else if ((w > 0) && (NW'(w) <= r_n)) begin
                        n_eb[w] = r_sb[(w > 0) ? w - 1 : 0];
                        n_el[w] = r_sl[(w > 0) ? w - 1 : 0];
                        n_eu[w] = 1'b1;
                    end else begin
                        n_eb[w] = '0;
                        n_el[w] = '0;
                        n_eu[w] = 1'b0;
                    end
                end
                n_res.success      = 1'b1;
                n_res.placed_begin = r_bstart;
                n_res.placed_slot  = w_bpos_ext[1:0];
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_take) begin
            n_found  = 1'b1;
            n_bstart = r_cursor[31:0];
            n_bsize  = r_size;
            n_bpos   = r_k;
        end
    end

    // result register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if ((r_state == ST_DONE) && (!r_out_valid || i_out_ready)) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_len       <= '0;
            r_eb        <= '{default: '0};
            r_el        <= '{default: '0};
            r_eu        <= '{default: 1'b0};
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_eb        <= n_eb;
            r_el        <= n_el;
            r_eu        <= n_eu;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_REGION_BASE) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_idx == CFG_REGION_LENGTH) begin
                    r_len <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out        <= n_out;
        r_res        <= n_res;
        r_sb         <= n_sb;
        r_sl         <= n_sl;
        r_taken      <= n_taken;
        r_j          <= n_j;
        r_best_idx   <= n_best_idx;
        r_have       <= n_have;
        r_best_begin <= n_best_begin;
        r_best_len   <= n_best_len;
        r_n          <= n_n;
        r_k          <= n_k;
        r_bpos       <= n_bpos;
        r_end        <= n_end;
        r_cursor     <= n_cursor;
        r_gap_end    <= n_gap_end;
        r_size       <= n_size;
        r_bsize      <= n_bsize;
        r_ext        <= n_ext;
        r_bstart     <= n_bstart;
        r_req        <= n_req;
        r_policy     <= n_policy;
        r_found      <= n_found;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* sv/cpp_alu.sv */
// shared 33-bit add and subtract unit with compare flags
// depends on cpp_pkg
module cpp_alu import cpp_pkg::*; (
    input  t_alu_op     i_op,
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output t_alu_res    o_res
);

    logic [33:0] w_sum;

    always_comb begin
        unique case (i_op)
            ALU_ADD: w_sum = {1'b0, i_a} + {1'b0, i_b};
            ALU_SUB: w_sum = {1'b0, i_a} - {1'b0, i_b};
            default: w_sum = '0;
        endcase
    end

    assign o_res.value = w_sum[32:0];
    assign o_res.lt    = (i_op == ALU_SUB) & w_sum[33];
    assign o_res.zero  = (w_sum == '0);

endmodule

/* tb/sv/cpp_placement_checker.sv */
// scoreboard for the contiguous partition placer: keeps its own slot table and region,
// predicts the result of every accepted request and compares it with the returned one
// depends on cpp_pkg
`timescale 1ns / 100ps

module cpp_placement_checker import cpp_pkg::*; #(
    parameter int SLOT_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [33:0] ADDR_TOP    = 34'h1_0000_0000;

    logic [31:0] region_base_q;
    logic [31:0] region_length_q;
    logic [31:0] tbl_begin  [SLOT_COUNT];
    logic [31:0] tbl_length [SLOT_COUNT];
    logic        tbl_used   [SLOT_COUNT];
    t_out        expected_placements [$];
    int          fail_total = 0;

    task automatic clear_table();
        region_base_q   = '0;
        region_length_q = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_begin[i]  = '0;
            tbl_length[i] = '0;
            tbl_used[i]   = 1'b0;
        end
    endtask

    function automatic t_out place_request(input t_in req);
        t_out        res;
        int unsigned order [SLOT_COUNT];
        int unsigned n_used, i, j, k, w, best_pos;
        logic [33:0] region_end, cursor, gap_end, gap_size, slot_end;
        logic [33:0] best_start, best_size;
        logic        found, take;
        logic [31:0] new_begin  [SLOT_COUNT];
        logic [31:0] new_length [SLOT_COUNT];
        logic        new_used   [SLOT_COUNT];

        res = '0;
        if (req.cmd == CMD_LOAD) begin
            res.placed_slot = req.slot_index;
            if (req.slot_index < SLOT_COUNT) begin
                tbl_begin[req.slot_index]  = req.slot_begin;
                tbl_length[req.slot_index] = req.slot_length;
                tbl_used[req.slot_index]   = req.slot_in_use;
                res.success = 1'b1;
            end
            return res;
        end

        // stable insertion sort of the used slots by start
        n_used = 0;
        for (i = 0; i < SLOT_COUNT; i++) begin
            if (tbl_used[i]) begin
                j = n_used;
                while (j > 0 && tbl_begin[order[j - 1]] > tbl_begin[i]) begin
                    order[j] = order[j - 1];
                    j--;
                end
                order[j] = i;
                n_used++;
            end
        end
        if (n_used >= SLOT_COUNT)
            return res;

        region_end = {2'b00, region_base_q} + {2'b00, region_length_q};
        if (region_end > ADDR_TOP)
            region_end = ADDR_TOP;
        cursor     = {2'b00, region_base_q};
        found      = 1'b0;
        best_start = '0;
        best_size  = '0;
        best_pos   = 0;

        for (k = 0; k <= n_used; k++) begin
            gap_end = region_end;
            if (k < n_used && {2'b00, tbl_begin[order[k]]} < gap_end)
                gap_end = {2'b00, tbl_begin[order[k]]};
            if (gap_end > cursor) begin
                gap_size = gap_end - cursor;
                if (gap_size >= {2'b00, req.request_length}) begin
                    if (!found)
                        take = 1'b1;
                    else if (req.fit_policy == POL_BEST)
                        take = gap_size < best_size;
                    else if (req.fit_policy == POL_WORST)
                        take = gap_size > best_size;
                    else
                        take = 1'b0;
                    if (take) begin
                        found      = 1'b1;
                        best_start = cursor;
                        best_size  = gap_size;
                        best_pos   = k;
                    end
                end
            end
            if (k < n_used) begin
                slot_end = {2'b00, tbl_begin[order[k]]} + {2'b00, tbl_length[order[k]]};
                if (slot_end > cursor)
                    cursor = slot_end;
            end
        end

        if (!found)
            return res;

        for (i = 0; i < SLOT_COUNT; i++) begin
            new_begin[i]  = '0;
            new_length[i] = '0;
            new_used[i]   = 1'b0;
        end
        w = 0;
        for (k = 0; k <= n_used && w < SLOT_COUNT; k++) begin
            if (k == best_pos) begin
                new_begin[w]  = best_start[31:0];
                new_length[w] = req.request_length;
                new_used[w]   = 1'b1;
                w++;
            end
            if (k < n_used && w < SLOT_COUNT) begin
                new_begin[w]  = tbl_begin[order[k]];
                new_length[w] = tbl_length[order[k]];
                new_used[w]   = 1'b1;
                w++;
            end
        end
        tbl_begin  = new_begin;
        tbl_length = new_length;
        tbl_used   = new_used;

        res.success      = 1'b1;
        res.placed_begin = best_start[31:0];
        res.placed_slot  = 2'(best_pos);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            clear_table();
            expected_placements.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_placements.size() == 0) begin
                    fail_total++;
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, i_out_data);
                end else begin
                    want = expected_placements.pop_front();
                    check_field("success", 32'(want.success), 32'(i_out_data.success));
                    check_field("placed_begin", want.placed_begin, i_out_data.placed_begin);
                    check_field("placed_slot", 32'(want.placed_slot),
                                32'(i_out_data.placed_slot));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_REGION_BASE)
                    region_base_q = i_cfg_data;
                else
                    region_length_q = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                expected_placements.push_back(place_request(i_in_data));
        end
        o_pending    <= expected_placements.size();
        o_fail_count <= fail_total;
    end

endmodule

/* tb/sv/tb_contiguous_partition_placer.sv */
// top of the contiguous partition placer testbench: clock, reset, region settings,
// directed and random load/allocate requests with random stalls on both sides, verdict
// depends on cpp_pkg, contiguous_partition_placer and cpp_placement_checker
`timescale 1ns / 100ps

module tb_contiguous_partition_placer;
    import cpp_pkg::*;

    localparam logic [1:0] POL_SPARE      = 2'd3;
    localparam int         SETTLE_CYCLES  = 60;
    localparam int         WATCHDOG_LIMIT = 1000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in         in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_idx   = CFG_REGION_BASE;
    logic [31:0] cfg_data  = '0;
    logic        in_ready;
    logic        out_valid;
    t_out        out_data;
    int          fail_count;
    int          pending;

    bit          calm         = 1'b0;
    int unsigned reqs_sent    = 0;
    int unsigned stuck_cycles = 0;
    logic [31:0] base_now     = '0;
    int unsigned span_now     = 0;

    contiguous_partition_placer u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    cpp_placement_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles", $time, stuck_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side
    initial begin : sink
        int unsigned stall;
        forever begin
            @(negedge clk);
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic t_in random_req();
        t_in r;
        r.cmd            = 1'($urandom_range(0, 1));
        r.slot_index     = 2'($urandom_range(0, 3));
        r.slot_begin     = $urandom();
        r.slot_length    = $urandom();
        r.slot_in_use    = 1'($urandom_range(0, 1));
        r.request_length = $urandom();
        r.fit_policy     = 2'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic t_in load_req(input logic [1:0] idx, input logic [31:0] beg,
                                     input logic [31:0] len, input logic used);
        t_in r;
        r             = random_req();
        r.cmd         = CMD_LOAD;
        r.slot_index  = idx;
        r.slot_begin  = beg;
        r.slot_length = len;
        r.slot_in_use = used;
        return r;
    endfunction

    function automatic t_in alloc_req(input logic [31:0] len, input logic [1:0] policy);
        t_in r;
        r                = random_req();
        r.cmd            = CMD_ALLOC;
        r.request_length = len;
        r.fit_policy     = policy;
        return r;
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            2:       return base_now - $urandom_range(0, 15);
            default: return base_now + $urandom_range(0, span_now);
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return '0;
            default: return $urandom_range(1, span_now / 4 + 1);
        endcase
    endfunction

    function automatic logic [31:0] pick_req();
        case ($urandom_range(0, 11))
            0:       return $urandom();
            1:       return '0;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom_range(1, span_now / 3 + 1);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input t_in req);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        reqs_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
    endtask

    task automatic set_region(input logic [31:0] base, input logic [31:0] length);
        drain();
        write_cfg(CFG_REGION_BASE, base);
        write_cfg(CFG_REGION_LENGTH, length);
        cfg_we   <= 1'b0;
        base_now = base;
        span_now = (length > 8000) ? 8000 : length;
    endtask

    task automatic run_directed();
        set_region(32'd100, 32'd1000);
        send_req(alloc_req(32'd0, POL_FIRST));
        send_req(alloc_req(32'd1000, POL_BEST));
        send_req(alloc_req(32'd1, POL_FIRST));
        send_req(load_req(2'd0, 32'd300, 32'd100, 1'b1));
        send_req(load_req(2'd1, 32'd150, 32'd50, 1'b1));
        send_req(load_req(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_req(load_req(2'd3, 32'd700, 32'd100, 1'b1));
        send_req(alloc_req(32'd60, POL_FIRST));
        // full table
        send_req(alloc_req(32'd1, POL_WORST));
        send_req(load_req(2'd1, 32'd0, 32'd0, 1'b0));
        // two largest gaps of equal size
        send_req(alloc_req(32'd60, POL_WORST));
        send_req(load_req(2'd2, 32'd0, 32'd0, 1'b0));
        send_req(alloc_req(32'd60, POL_BEST));
        send_req(load_req(2'd1, 32'd0, 32'd0, 1'b0));
        send_req(alloc_req(32'd60, POL_SPARE));
        // overlapping, equal-start and out-of-region slots
        send_req(load_req(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_req(load_req(2'd1, 32'd50, 32'd200, 1'b1));
        send_req(load_req(2'd2, 32'd50, 32'd10, 1'b1));
        send_req(load_req(2'd3, 32'd0, 32'd0, 1'b0));
        send_req(alloc_req(32'd850, POL_FIRST));
        // region end past the top of the address space
        set_region(32'hFFFF_FF00, 32'hFFFF_FFFF);
        send_req(load_req(2'd3, 32'd0, 32'd0, 1'b0));
        send_req(alloc_req(32'd256, POL_WORST));
        send_req(load_req(2'd0, 32'd0, 32'd0, 1'b0));
        send_req(alloc_req(32'hFFFF_FFFF, POL_BEST));
    endtask

    task automatic run_phase(input logic [31:0] base, input logic [31:0] length,
                             input int unsigned quota);
        int unsigned stop_at, n_used, first, n_loads, n_allocs, s;
        set_region(base, length);
        stop_at = reqs_sent + quota;
        while (reqs_sent < stop_at) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4)) send_req(random_req());
            end else begin
                // table set-up followed by a burst of allocations
                n_used  = $urandom_range(0, 4);
                first   = $urandom_range(0, 3);
                n_loads = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 4;
                for (s = 0; s < n_loads; s++)
                    send_req(load_req(2'((first + s) % 4), pick_pos(), pick_size(),
                                      s < n_used));
                n_allocs = $urandom_range(1, 4);
                for (s = 0; s < n_allocs; s++)
                    send_req(alloc_req(pick_req(), 2'($urandom_range(0, 3))));
            end
            if ($urandom_range(0, 29) == 0)
                drain();
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_phase(32'd0, 32'd0, 120);
        run_phase(32'd0, 32'hFFFF_FFFF, 260);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 200);
        run_phase(32'd1000, 32'd4000, 300);
        run_phase($urandom(), $urandom_range(16, 5000), 300);
        run_phase($urandom(), $urandom(), 260);
        run_phase(32'd100, 32'd1000, 300);
        drain();
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
